FILE: rtl/hdrtm_pkg.sv
// Package: constants, widths and divider step functions for the HDR tone map and grade block.
package hdrtm_pkg;

  localparam int FRAC_BITS = 12;
  localparam int IN_W      = 16;
  localparam int OUT_W     = FRAC_BITS + 1;
  localparam int X_W       = 19;
  localparam int DW        = 53;
  localparam int TD_STEPS  = FRAC_BITS + 2;
  localparam int TQ_W      = FRAC_BITS + 2;
  localparam int W_STEPS   = 2 * (FRAC_BITS + 1);
  localparam int W_STAGES  = W_STEPS / 2;
  localparam int WQ_W      = FRAC_BITS + 4;
  localparam int WR_W      = 15;
  localparam int N_W       = 15;

  localparam logic [OUT_W-1:0] ONE  = OUT_W'(1 << FRAC_BITS);
  localparam logic [OUT_W-1:0] HALF = OUT_W'(1 << (FRAC_BITS - 1));

  localparam logic [13:0] K_NUM_A  = 14'd10281;
  localparam logic [13:0] K_NUM_B  = 14'd123;
  localparam logic [13:0] K_DEN_A  = 14'd9953;
  localparam logic [13:0] K_DEN_B  = 14'd2417;
  localparam logic [13:0] K_DEN_C  = 14'd573;
  localparam logic [13:0] K_LUMA_R = 14'd871;
  localparam logic [13:0] K_LUMA_G = 14'd2929;
  localparam logic [13:0] K_LUMA_B = 14'd296;
  localparam logic [14:0] GAIN_MIN = 15'd205;
  localparam logic [14:0] WP_MIN   = 15'd1024;
  localparam logic [14:0] WP_MAX   = 15'd16384;
  localparam logic [13:0] GAIN2    = 14'd8192;
  localparam logic signed [11:0] LIFT_MAX = 12'sd1024;
  localparam logic signed [11:0] LIFT_MIN = -12'sd1024;

  localparam logic [2:0] CFG_TONE_MODE  = 3'd0;
  localparam logic [2:0] CFG_EXPOSURE   = 3'd1;
  localparam logic [2:0] CFG_WHITE      = 3'd2;
  localparam logic [2:0] CFG_CONTRAST   = 3'd3;
  localparam logic [2:0] CFG_SATURATION = 3'd4;
  localparam logic [2:0] CFG_LIFT       = 3'd5;

  localparam logic [1:0] TONE_LINEAR   = 2'd0;
  localparam logic [1:0] TONE_REINHARD = 2'd1;
  localparam logic [1:0] TONE_ACES     = 2'd2;

  typedef struct packed {
    logic          b;
    logic [DW-1:0] r;
  } td_step_t;

  typedef struct packed {
    logic            b;
    logic [WR_W-1:0] r;
  } wd_step_t;

  // remainder r < den; shift in a zero and try subtracting
  function automatic td_step_t td_step(input logic [DW-1:0] r, input logic [DW-1:0] den);
    logic [DW:0] r2;
    logic [DW:0] diff;
    td_step_t    res;
    r2   = {r, 1'b0};
    diff = r2 - {1'b0, den};
    if (r2 >= {1'b0, den}) begin
      res.b = 1'b1;
      res.r = diff[DW-1:0];
    end else begin
      res.b = 1'b0;
      res.r = r2[DW-1:0];
    end
    return res;
  endfunction

  function automatic wd_step_t wd_step(input logic [WR_W-1:0] r, input logic dbit,
                                       input logic [WR_W-1:0] den);
    logic [WR_W:0] r2;
    logic [WR_W:0] diff;
    wd_step_t      res;
    r2   = {r, dbit};
    diff = r2 - {1'b0, den};
    if (r2 >= {1'b0, den}) begin
      res.b = 1'b1;
      res.r = diff[WR_W-1:0];
    end else begin
      res.b = 1'b0;
      res.r = r2[WR_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/hdr_tone_map_color_grade.sv
// Top level: pipelined HDR tone mapping and colour grading of one RGB pixel per clock.
//
// Usage: pulse start with a pixel on in_red_in/in_green_in/in_blue_in (Q4.12).
// The item is taken at any edge with start high and busy low; busy is low
// whenever reset is released, so one pixel can be taken every clock.
// Results leave on out_red_out/out_green_out/out_blue_out (Q1.12, 0..4096)
// for one cycle, marked by out_valid. Throughput is one item per cycle; the
// pipeline holds a fourteen-stage tone divider and a thirteen-stage white
// point divider (two quotient bits a stage).
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write only
// while no item is in flight. cfg_ready is high out of reset.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// registers: ACES curve, unity exposure, white point, contrast and saturation,
// zero lift. The receiver cannot stall: every result is shown exactly once.
module hdr_tone_map_color_grade
  import hdrtm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [IN_W-1:0]  in_red_in,
  input  logic [IN_W-1:0]  in_green_in,
  input  logic [IN_W-1:0]  in_blue_in,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_red_out,
  output logic [OUT_W-1:0] out_green_out,
  output logic [OUT_W-1:0] out_blue_out,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [14:0]      cfg_data
);

  // configuration
  logic [1:0]         tone_mode_r;
  logic [14:0]        exposure_r;
  logic [14:0]        white_r;
  logic [13:0]        contrast_r;
  logic [13:0]        saturation_r;
  logic signed [11:0] lift_r;

  logic [14:0]        gain_c;
  logic [14:0]        wp_c;
  logic [13:0]        con_c;
  logic [13:0]        sat_c;
  logic signed [11:0] lift_c;

  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_mode_r  <= TONE_ACES;
      exposure_r   <= 15'd4096;
      white_r      <= 15'd4096;
      contrast_r   <= 14'd4096;
      saturation_r <= 14'd4096;
      lift_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TONE_MODE:  tone_mode_r  <= cfg_data[1:0];
        CFG_EXPOSURE:   exposure_r   <= cfg_data;
        CFG_WHITE:      white_r      <= cfg_data;
        CFG_CONTRAST:   contrast_r   <= cfg_data[13:0];
        CFG_SATURATION: saturation_r <= cfg_data[13:0];
        CFG_LIFT:       lift_r       <= $signed(cfg_data[11:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    gain_c = (exposure_r < GAIN_MIN) ? GAIN_MIN : exposure_r;
    wp_c   = (white_r < WP_MIN) ? WP_MIN : ((white_r > WP_MAX) ? WP_MAX : white_r);
    con_c  = (contrast_r > GAIN2) ? GAIN2 : contrast_r;
    sat_c  = (saturation_r > GAIN2) ? GAIN2 : saturation_r;
    lift_c = (lift_r < LIFT_MIN) ? LIFT_MIN : ((lift_r > LIFT_MAX) ? LIFT_MAX : lift_r);
  end

  // pipeline registers
  logic                v1_r, v2_r, v3_r, v4_r;
  logic [IN_W-1:0]     in1_r  [3];
  logic [X_W-1:0]      x2_r   [3];
  logic [X_W-1:0]      x3_r   [3];
  logic [2*X_W-1:0]    xx3_r  [3];
  logic [25:0]         nb3_r  [3];
  logic [30:0]         db3_r  [3];
  logic [DW-1:0]       num4_r [3];
  logic [DW-1:0]       den4_r [3];

  logic                tv_r   [TD_STEPS];
  logic [DW-1:0]       tr_r   [TD_STEPS][3];
  logic [DW-1:0]       tden_r [TD_STEPS][3];
  logic [TQ_W-1:0]     tq_r   [TD_STEPS][3];
  logic                tsat_r [TD_STEPS][3];

  logic                wv_r   [W_STAGES];
  logic [WR_W-1:0]     wrem_r [W_STAGES][3];
  logic [W_STEPS-1:0]  wdv_r  [W_STAGES][3];
  logic [WQ_W-1:0]     wq_r   [W_STAGES][3];

  logic                gv1_r, gv2_r, gv3_r, gv4_r, gv5_r;
  logic [27:0]         gsum1_r;
  logic [N_W-1:0]      gn1_r  [3];
  logic [15:0]         gl2_r, gl3_r;
  logic signed [16:0]  gd2_r  [3];
  logic signed [31:0]  gps3_r [3];
  logic signed [20:0]  gs4_r  [3];
  logic signed [35:0]  gpc5_r [3];
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_r  [3];

  logic [IN_W-1:0]     in_c   [3];
  logic [X_W-1:0]      x_nxt  [3];
  logic [DW-1:0]       num_nxt [3];
  logic [DW-1:0]       den_nxt [3];
  logic [DW-1:0]       tr_nxt  [TD_STEPS][3];
  logic [TQ_W-1:0]     tq_nxt  [TD_STEPS][3];
  logic                tsat_nxt [3];
  logic [OUT_W-1:0]    y_c     [3];
  logic [WR_W-1:0]     wrem_nxt [W_STAGES][3];
  logic [W_STEPS-1:0]  wdv_nxt  [W_STAGES][3];
  logic [WQ_W-1:0]     wq_nxt   [W_STAGES][3];
  logic [N_W-1:0]      n_c      [3];
  logic [27:0]         gsum_nxt;
  logic [15:0]         luma_nxt;
  logic signed [20:0]  s_nxt    [3];
  logic [OUT_W-1:0]    c_nxt    [3];

  assign in_c[0] = in_red_in;
  assign in_c[1] = in_green_in;
  assign in_c[2] = in_blue_in;

  always_comb begin
    logic [31:0]        psum;
    logic [DW:0]        diff0;
    logic [TQ_W:0]      yq;
    logic [WQ_W:0]      nq;
    logic [W_STEPS-1:0] dv;
    logic [WR_W-1:0]    rem;
    logic [WQ_W-1:0]    q;
    wd_step_t           s1;
    wd_step_t           s2;
    td_step_t           ts;
    logic signed [31:0] t4;
    logic signed [31:0] sh4;
    logic signed [35:0] t6;
    logic signed [35:0] c6;
    gsum_nxt = '0;
    for (int ch = 0; ch < 3; ch++) begin
      // exposure
      psum = 32'(in1_r[ch]) * 32'(gain_c) + 32'(HALF);
      x_nxt[ch] = psum[FRAC_BITS+X_W-1:FRAC_BITS];

      // tone operator numerator and denominator
      case (tone_mode_r)
        TONE_LINEAR: begin
          num_nxt[ch] = DW'(x3_r[ch]);
          den_nxt[ch] = DW'(ONE);
        end
        TONE_REINHARD: begin
          num_nxt[ch] = DW'(x3_r[ch]);
          den_nxt[ch] = DW'(ONE) + DW'(x3_r[ch]);
        end
        default: begin
          num_nxt[ch] = DW'(xx3_r[ch]) * DW'(K_NUM_A) + (DW'(nb3_r[ch]) << FRAC_BITS);
          den_nxt[ch] = DW'(xx3_r[ch]) * DW'(K_DEN_A) + (DW'(db3_r[ch]) << FRAC_BITS)
                        + (DW'(K_DEN_C) << (2 * FRAC_BITS));
        end
      endcase

      // tone divider, first step carries the integer bit and the overflow test
      diff0 = {1'b0, num4_r[ch]} - {1'b0, den4_r[ch]};
      tsat_nxt[ch] = {1'b0, num4_r[ch]} >= {den4_r[ch], 1'b0};
      if (tsat_nxt[ch]) begin
        tr_nxt[0][ch] = '0;
        tq_nxt[0][ch] = '0;
      end else if (num4_r[ch] >= den4_r[ch]) begin
        tr_nxt[0][ch] = diff0[DW-1:0];
        tq_nxt[0][ch] = TQ_W'(1);
      end else begin
        tr_nxt[0][ch] = num4_r[ch];
        tq_nxt[0][ch] = '0;
      end
      for (int k = 1; k < TD_STEPS; k++) begin
        ts = td_step(tr_r[k-1][ch], tden_r[k-1][ch]);
        tr_nxt[k][ch] = ts.r;
        tq_nxt[k][ch] = {tq_r[k-1][ch][TQ_W-2:0], ts.b};
      end

      yq = ({1'b0, tq_r[TD_STEPS-1][ch]} + (TQ_W+1)'(1)) >> 1;
      if (tsat_r[TD_STEPS-1][ch] || yq > (TQ_W+1)'(ONE))
        y_c[ch] = ONE;
      else
        y_c[ch] = yq[OUT_W-1:0];

      // white point divider, two quotient bits a stage
      for (int j = 0; j < W_STAGES; j++) begin
        if (j == 0) begin
          dv  = {y_c[ch], (W_STEPS-OUT_W)'(0)};
          rem = '0;
          q   = '0;
        end else begin
          dv  = wdv_r[j-1][ch];
          rem = wrem_r[j-1][ch];
          q   = wq_r[j-1][ch];
        end
        s1 = wd_step(rem, dv[W_STEPS-1], wp_c);
        s2 = wd_step(s1.r, dv[W_STEPS-2], wp_c);
        wrem_nxt[j][ch] = s2.r;
        wdv_nxt[j][ch]  = {dv[W_STEPS-3:0], 2'b00};
        wq_nxt[j][ch]   = {q[WQ_W-3:0], s1.b, s2.b};
      end

      nq = ({1'b0, wq_r[W_STAGES-1][ch]} + (WQ_W+1)'(1)) >> 1;
      n_c[ch] = nq[N_W-1:0];

      // saturation about luma
      t4  = gps3_r[ch] + 32'(HALF);
      sh4 = t4 >>> FRAC_BITS;
      s_nxt[ch] = $signed(sh4[20:0]) + $signed({5'b0, gl3_r});

      // contrast, lift and clamp
      t6 = gpc5_r[ch] + 36'(HALF);
      c6 = (t6 >>> FRAC_BITS) + $signed(36'(HALF)) + 36'(lift_c);
      if (c6 < 36'sd0)
        c_nxt[ch] = '0;
      else if (c6 > 36'(ONE))
        c_nxt[ch] = ONE;
      else
        c_nxt[ch] = c6[OUT_W-1:0];
    end
    gsum_nxt = 28'(n_c[0]) * 28'(K_LUMA_R) + 28'(n_c[1]) * 28'(K_LUMA_G)
               + 28'(n_c[2]) * 28'(K_LUMA_B);
    luma_nxt = 16'((gsum1_r + 28'(HALF)) >> FRAC_BITS);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      for (int k = 0; k < TD_STEPS; k++) tv_r[k] <= 1'b0;
      for (int j = 0; j < W_STAGES; j++) wv_r[j] <= 1'b0;
      gv1_r <= 1'b0;
      gv2_r <= 1'b0;
      gv3_r <= 1'b0;
      gv4_r <= 1'b0;
      gv5_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      tv_r[0] <= v4_r;
      for (int k = 1; k < TD_STEPS; k++) tv_r[k] <= tv_r[k-1];
      wv_r[0] <= tv_r[TD_STEPS-1];
      for (int j = 1; j < W_STAGES; j++) wv_r[j] <= wv_r[j-1];
      gv1_r <= wv_r[W_STAGES-1];
      gv2_r <= gv1_r;
      gv3_r <= gv2_r;
      gv4_r <= gv3_r;
      gv5_r <= gv4_r;
      out_valid_r <= gv5_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (start && !busy) in1_r[ch] <= in_c[ch];
      x2_r[ch]   <= x_nxt[ch];
      x3_r[ch]   <= x2_r[ch];
      xx3_r[ch]  <= (2*X_W)'(x2_r[ch]) * (2*X_W)'(x2_r[ch]);
      nb3_r[ch]  <= 26'(x2_r[ch]) * 26'(K_NUM_B);
      db3_r[ch]  <= 31'(x2_r[ch]) * 31'(K_DEN_B);
      num4_r[ch] <= num_nxt[ch];
      den4_r[ch] <= den_nxt[ch];
      tden_r[0][ch] <= den4_r[ch];
      tsat_r[0][ch] <= tsat_nxt[ch];
      for (int k = 0; k < TD_STEPS; k++) begin
        tr_r[k][ch] <= tr_nxt[k][ch];
        tq_r[k][ch] <= tq_nxt[k][ch];
      end
      for (int k = 1; k < TD_STEPS; k++) begin
        tden_r[k][ch] <= tden_r[k-1][ch];
        tsat_r[k][ch] <= tsat_r[k-1][ch];
      end
      for (int j = 0; j < W_STAGES; j++) begin
        wrem_r[j][ch] <= wrem_nxt[j][ch];
        wdv_r[j][ch]  <= wdv_nxt[j][ch];
        wq_r[j][ch]   <= wq_nxt[j][ch];
      end
      gn1_r[ch]  <= n_c[ch];
      gd2_r[ch]  <= $signed({2'b00, gn1_r[ch]}) - $signed({1'b0, luma_nxt});
      gps3_r[ch] <= gd2_r[ch] * $signed({1'b0, sat_c});
      gs4_r[ch]  <= s_nxt[ch];
      gpc5_r[ch] <= (gs4_r[ch] - $signed(21'(HALF))) * $signed({1'b0, con_c});
      out_r[ch]  <= c_nxt[ch];
    end
    gsum1_r <= gsum_nxt;
    gl2_r   <= luma_nxt;
    gl3_r   <= gl2_r;
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_r[0];
  assign out_green_out = out_r[1];
  assign out_blue_out  = out_r[2];

  // checks
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red_out <= ONE) && (out_green_out <= ONE) && (out_blue_out <= ONE))
    else $error("result above unity");

  a_tone_rem: assert property (@(posedge clk) disable iff (!rst_n)
    tv_r[TD_STEPS-1] |-> (tr_r[TD_STEPS-1][0] < tden_r[TD_STEPS-1][0])
                      && (tr_r[TD_STEPS-1][1] < tden_r[TD_STEPS-1][1])
                      && (tr_r[TD_STEPS-1][2] < tden_r[TD_STEPS-1][2]))
    else $error("tone divider remainder not below divisor");

  a_wp_rem: assert property (@(posedge clk) disable iff (!rst_n)
    wv_r[W_STAGES-1] |-> (wrem_r[W_STAGES-1][0] < wp_c) && (wrem_r[W_STAGES-1][1] < wp_c)
                      && (wrem_r[W_STAGES-1][2] < wp_c))
    else $error("white point divider remainder not below divisor");

endmodule
